/* design/paeg_pkg.sv */
// Shared constants and controller/datapath handshake types for the edge generator.
package paeg_pkg;

  localparam int unsigned RandW = 32;
  localparam int unsigned VidW  = 16;
  localparam int unsigned CfgW  = 17;

  localparam logic [CfgW-1:0] VertexCountRst = 17'd1024;
  localparam int unsigned     SeedCount      = 2;

  typedef struct packed {
    logic capture;
    logic mul;
    logic rd;
    logic ld_seed;
    logic ld_small;
    logic ld_edge;
    logic wr_from;
    logic advance;
  } paeg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic two_vtx;
    logic started;
  } paeg_stat_t;

endpackage

/* design/paeg_if.sv */
// Channel interfaces: random input, configuration write and edge output.
interface paeg_in_if;
  import paeg_pkg::*;
  logic             valid;
  logic             ready;
  logic [RandW-1:0] random_fraction;
  modport source (output valid, output random_fraction, input ready);
  modport sink (input valid, input random_fraction, output ready);
endinterface

interface paeg_cfg_if;
  import paeg_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] vertex_count;
  modport source (output valid, output vertex_count, input ready);
  modport sink (input valid, input vertex_count, output ready);
endinterface

interface paeg_out_if;
  import paeg_pkg::*;
  logic            valid;
  logic            ready;
  logic [VidW-1:0] edge_from;
  logic [VidW-1:0] edge_to;
  logic            last_edge;
  modport source (output valid, output edge_from, output edge_to, output last_edge,
                  input ready);
  modport sink (input valid, input edge_from, input edge_to, input last_edge,
                output ready);
endinterface

/* design/paeg_dp.sv */
// Datapath: config register, index multiply, endpoint memory, counters and output register.
module paeg_dp #(
  parameter int unsigned MAX_VERTICES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  paeg_pkg::paeg_cmd_t          cmd_i,
  output paeg_pkg::paeg_stat_t         stat_o,
  input  logic [paeg_pkg::RandW-1:0]   random_fraction_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [paeg_pkg::CfgW-1:0]    vertex_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [paeg_pkg::VidW-1:0]    edge_from_o,
  output logic [paeg_pkg::VidW-1:0]    edge_to_o,
  output logic                         last_edge_o
);
  import paeg_pkg::*;

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW    = $clog2(2 * MAX_VERTICES);
  localparam int unsigned EW    = (NW > CfgW) ? NW : CfgW;
  localparam int unsigned PW    = RandW + AW;
  localparam int unsigned Depth = 2 * MAX_VERTICES;

  logic [CfgW-1:0]  vc_q;
  logic [RandW-1:0] r_q;
  logic [AW-1:0]    idx_q;
  logic [AW-1:0]    cnt_q;
  logic [NW-1:0]    nv_q;
  logic             started_q;
  logic             last_q;
  logic [VW-1:0]    rdata_q;
  logic             out_valid_q;
  logic [VidW-1:0]  from_q;
  logic [VidW-1:0]  to_q;
  logic             olast_q;

  logic [VW-1:0]    mem [Depth];

  logic [EW-1:0]    vc_ext;
  logic [NW-1:0]    n_w;
  logic [PW-1:0]    prod;
  logic [VW-1:0]    from_w;
  logic [NW-1:0]    nv_inc;
  logic             edge_last;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VW-1:0]    wdata;

  always_comb begin
    vc_ext = EW'(vc_q);
    if (vc_ext < EW'(SeedCount)) begin
      n_w = NW'(SeedCount);
    end else if (vc_ext > EW'(MAX_VERTICES)) begin
      n_w = NW'(MAX_VERTICES);
    end else begin
      n_w = NW'(vc_ext);
    end
  end

  assign prod      = PW'(r_q) * PW'(cnt_q);
  assign from_w    = (idx_q < AW'(SeedCount)) ? VW'(idx_q) : rdata_q;
  assign nv_inc    = nv_q + NW'(1);
  assign edge_last = (nv_inc >= n_w);

  assign we    = cmd_i.wr_from | cmd_i.advance;
  assign waddr = cmd_i.advance ? {cnt_q[AW-1:1], 1'b1} : cnt_q;
  assign wdata = cmd_i.advance ? VW'(nv_q) : from_w;

  assign cfg_ready_o     = 1'b1;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;
  assign stat_o.two_vtx  = (n_w <= NW'(SeedCount));
  assign stat_o.started  = started_q;

  assign out_valid_o = out_valid_q;
  assign edge_from_o = from_q;
  assign edge_to_o   = to_q;
  assign last_edge_o = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VertexCountRst;
      cnt_q       <= AW'(SeedCount);
      nv_q        <= NW'(SeedCount);
      started_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vc_q <= vertex_count_i;
      end
      if (cmd_i.ld_seed) begin
        started_q <= 1'b1;
      end
      if (cmd_i.ld_edge) begin
        last_q <= edge_last;
      end
      if (cmd_i.ld_small || (cmd_i.advance && last_q)) begin
        cnt_q     <= AW'(SeedCount);
        nv_q      <= NW'(SeedCount);
        started_q <= 1'b0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + AW'(2);
        nv_q  <= nv_inc;
      end
      if (cmd_i.ld_seed || cmd_i.ld_small || cmd_i.ld_edge) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q <= random_fraction_i;
    end
    if (cmd_i.mul) begin
      idx_q <= prod[PW-1:RandW];
    end
    if (cmd_i.ld_seed) begin
      from_q  <= VidW'(0);
      to_q    <= VidW'(1);
      olast_q <= 1'b0;
    end else if (cmd_i.ld_small) begin
      from_q  <= VidW'(0);
      to_q    <= VidW'(1);
      olast_q <= 1'b1;
    end else if (cmd_i.ld_edge) begin
      from_q  <= VidW'(from_w);
      to_q    <= VidW'(nv_q);
      olast_q <= edge_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

endmodule

/* design/paeg_ctrl.sv */
// Controller: sequences multiply, seed edge, memory read, edge emit, appends and the two-vertex edge.
module paeg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  paeg_pkg::paeg_stat_t  stat_i,
  output paeg_pkg::paeg_cmd_t   cmd_o
);
  import paeg_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StSeed  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StEdge  = 3'd4;
  localparam logic [2:0] StAdv   = 3'd5;
  localparam logic [2:0] StSmall = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        if (stat_i.two_vtx) begin
          state_d = StSmall;
        end else if (stat_i.started) begin
          state_d = StRead;
        end else begin
          state_d = StSeed;
        end
      end
      StSeed: begin
        if (stat_i.out_free) begin
          cmd_o.ld_seed = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StEdge;
      end
      StEdge: begin
        if (stat_i.out_free) begin
          cmd_o.ld_edge = 1'b1;
          cmd_o.wr_from = 1'b1;
          state_d       = StAdv;
        end
      end
      StAdv: begin
        cmd_o.advance = 1'b1;
        state_d       = StIdle;
      end
      StSmall: begin
        if (stat_i.out_free) begin
          cmd_o.ld_small = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/preferential_attachment_edge_gen_top.sv */
// Top level of the preferential-attachment edge generator.
//
//   port    dir  beat contents
//   rnd_i   in   random_fraction (32b)
//   cfg_i   in   vertex_count (17b), always ready
//   edge_o  out  edge_from (16b), edge_to (16b), last_edge (1b)
//
// One item in flight, stepping through accept, multiply, memory read, emit and append;
// a graph's first item adds a seed edge, and a two-vertex graph skips read and append.
// The endpoint memory is used once per step: the read, then writes in emit and append.
// A stalled edge_o holds seed, emit and small states; the output register frees rnd_i.
// Reset loads vertex_count 1024 and an empty graph; memory contents need no reset.
module preferential_attachment_edge_gen_top #(
  parameter int unsigned MAX_VERTICES = 65536
) (
  input logic         clk_i,
  input logic         rst_ni,
  paeg_in_if.sink     rnd_i,
  paeg_cfg_if.sink    cfg_i,
  paeg_out_if.source  edge_o
);
  import paeg_pkg::*;

  paeg_cmd_t  cmd;
  paeg_stat_t stat;

  paeg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rnd_i.valid),
    .in_ready_o (rnd_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  paeg_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .random_fraction_i (rnd_i.random_fraction),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_ready_o       (cfg_i.ready),
    .vertex_count_i    (cfg_i.vertex_count),
    .out_valid_o       (edge_o.valid),
    .out_ready_i       (edge_o.ready),
    .edge_from_o       (edge_o.edge_from),
    .edge_to_o         (edge_o.edge_to),
    .last_edge_o       (edge_o.last_edge)
  );

endmodule

/* design/paeg_chk.sv */
// Port-level checker for the edge generator, bound to the top level.
module paeg_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [paeg_pkg::VidW-1:0]  edge_from_i,
  input logic [paeg_pkg::VidW-1:0]  edge_to_i,
  input logic                       last_edge_i
);
  import paeg_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("edge beat appeared without an item in work");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(edge_from_i) && $stable(edge_to_i) && $stable(last_edge_i)))
    else $error("stalled edge beat changed");

endmodule

bind preferential_attachment_edge_gen_top paeg_chk u_paeg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rnd_i.valid),
  .in_ready_i  (rnd_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (edge_o.valid),
  .out_ready_i (edge_o.ready),
  .edge_from_i (edge_o.edge_from),
  .edge_to_i   (edge_o.edge_to),
  .last_edge_i (edge_o.last_edge)
);
